// ===== rtl/ceq_pkg.sv =====
// ----------------------------------------------------------------------------
// ceq_pkg
// Shared types and codes of the coalescing event queue.
// ----------------------------------------------------------------------------
package ceq_pkg;

    // field widths
    localparam int KIND_W  = 8;
    localparam int WORD_W  = 32;
    localparam int FILL_W  = 6;
    localparam int CFG_W   = 8;
    localparam int CFG_IDX_W = 1;

    // request actions
    localparam logic ACTION_PUSH = 1'b0;
    localparam logic ACTION_POP  = 1'b1;

    // response status codes
    localparam logic [1:0] STATUS_OK       = 2'd0;
    localparam logic [1:0] STATUS_REJECTED = 2'd1;
    localparam logic [1:0] STATUS_EMPTY    = 2'd2;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_QUEUE_ENABLED = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MOVE_CODE     = 1'd1;

    // one queued event
    typedef struct packed {
        logic [KIND_W-1:0]        kind;
        logic signed [WORD_W-1:0] first;
        logic signed [WORD_W-1:0] second;
    } entry_t;

    // controller to response register
    typedef struct packed {
        logic              load;
        logic              from_mem;
        logic [1:0]        status;
        logic [FILL_W-1:0] fill;
    } rsp_ctl_t;

    typedef enum logic {
        ST_IDLE,
        ST_POP_WAIT
    } ctrl_state_t;

endpackage

// ===== rtl/ceq_channels.sv =====
// ----------------------------------------------------------------------------
// ceq channels
// Valid/ready channels for queue requests and responses.
// ----------------------------------------------------------------------------
interface ceq_req_if;
    logic              valid;
    logic              ready;
    logic              action;
    logic [7:0]        event_kind;
    logic signed [31:0] first_value;
    logic signed [31:0] second_value;

    modport source (output valid, action, event_kind, first_value, second_value,
                    input ready);
    modport sink   (input valid, action, event_kind, first_value, second_value,
                    output ready);
endinterface

interface ceq_rsp_if;
    logic              valid;
    logic              ready;
    logic [1:0]        status;
    logic [7:0]        popped_kind;
    logic signed [31:0] popped_first;
    logic signed [31:0] popped_second;
    logic [5:0]        fill_level;

    modport source (output valid, status, popped_kind, popped_first, popped_second,
                    fill_level, input ready);
    modport sink   (input valid, status, popped_kind, popped_first, popped_second,
                    fill_level, output ready);
endinterface

// ===== rtl/ceq_store.sv =====
// ----------------------------------------------------------------------------
// ceq_store
// Entry memory: one write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module ceq_store #(
    parameter int QUEUE_DEPTH = 32,
    parameter int AW          = 5
) (
    input  logic            clk,
    input  logic            wr_en,
    input  logic [AW-1:0]   wr_addr,
    input  ceq_pkg::entry_t wr_data,
    input  logic            rd_en,
    input  logic [AW-1:0]   rd_addr,
    output ceq_pkg::entry_t rd_data
);
    import ceq_pkg::*;

    entry_t mem [QUEUE_DEPTH];
    entry_t rd_data_reg;

    // write port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // read port with registered read data
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== rtl/ceq_ctrl.sv =====
// ----------------------------------------------------------------------------
// ceq_ctrl
// Ring pointers, occupancy and request sequencing for the event queue.
// ----------------------------------------------------------------------------
module ceq_ctrl #(
    parameter int QUEUE_DEPTH = 32,
    parameter int AW          = 5
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         queue_enabled,
    input  logic [ceq_pkg::KIND_W-1:0]   move_code,
    input  logic                         req_valid,
    input  logic                         req_action,
    input  ceq_pkg::entry_t              req_entry,
    input  logic                         out_free,
    output logic                         req_ready,
    output logic                         wr_en,
    output logic [AW-1:0]                wr_addr,
    output ceq_pkg::entry_t              wr_data,
    output logic                         rd_en,
    output logic [AW-1:0]                rd_addr,
    output ceq_pkg::rsp_ctl_t            rsp_ctl
);
    import ceq_pkg::*;

    localparam int CW = $clog2(QUEUE_DEPTH + 1);
    localparam logic [AW-1:0] LAST_SLOT = AW'(QUEUE_DEPTH - 1);
    localparam logic [CW-1:0] FULL_COUNT = CW'(QUEUE_DEPTH);

    ctrl_state_t       state_reg, state_next;
    logic [AW-1:0]     read_slot_reg, read_slot_next;
    logic [AW-1:0]     write_slot_reg, write_slot_next;
    logic [CW-1:0]     occupancy_reg, occupancy_next;
    logic [KIND_W-1:0] newest_kind_reg, newest_kind_next;
    logic              ready;
    logic              is_move;
    logic              coalesce;

    function automatic logic [AW-1:0] slot_inc(input logic [AW-1:0] s);
        return (s == LAST_SLOT) ? '0 : s + AW'(1);
    endfunction

    function automatic logic [AW-1:0] slot_dec(input logic [AW-1:0] s);
        return (s == '0) ? LAST_SLOT : s - AW'(1);
    endfunction

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            read_slot_reg   <= '0;
            write_slot_reg  <= '0;
            occupancy_reg   <= '0;
            newest_kind_reg <= '0;
        end
        else
        begin
            state_reg       <= state_next;
            read_slot_reg   <= read_slot_next;
            write_slot_reg  <= write_slot_next;
            occupancy_reg   <= occupancy_next;
            newest_kind_reg <= newest_kind_next;
        end
    end

    assign ready     = (state_reg == ST_IDLE) && out_free;
    assign req_ready = ready;

    // newest entry is a move and this push is a move: overwrite its data
    assign is_move  = (req_entry.kind == move_code);
    assign coalesce = is_move && (occupancy_reg != '0) && (newest_kind_reg == move_code);

    // next state and memory commands
    always_comb
    begin
        state_next       = state_reg;
        read_slot_next   = read_slot_reg;
        write_slot_next  = write_slot_reg;
        occupancy_next   = occupancy_reg;
        newest_kind_next = newest_kind_reg;
        wr_en            = 1'b0;
        wr_addr          = write_slot_reg;
        wr_data          = req_entry;
        rd_en            = 1'b0;
        rd_addr          = read_slot_reg;
        rsp_ctl          = '0;

        case (state_reg)
            ST_IDLE:
            begin
                if (req_valid && ready)
                begin
                    if (req_action == ACTION_POP)
                    begin
                        if (occupancy_reg == '0)
                        begin
                            rsp_ctl.load   = 1'b1;
                            rsp_ctl.status = STATUS_EMPTY;
                        end
                        else
                        begin
                            rd_en          = 1'b1;
                            read_slot_next = slot_inc(read_slot_reg);
                            occupancy_next = occupancy_reg - CW'(1);
                            state_next     = ST_POP_WAIT;
                        end
                    end
                    else if (!queue_enabled)
                    begin
                        rsp_ctl.load   = 1'b1;
                        rsp_ctl.status = STATUS_REJECTED;
                    end
                    else
                    begin
                        rsp_ctl.load   = 1'b1;
                        rsp_ctl.status = STATUS_OK;
                        if (coalesce)
                        begin
                            wr_en   = 1'b1;
                            wr_addr = slot_dec(write_slot_reg);
                        end
                        else if (occupancy_reg == FULL_COUNT)
                        begin
                            // full: a move is dropped, anything else evicts the oldest
                            if (!is_move)
                            begin
                                wr_en            = 1'b1;
                                read_slot_next   = slot_inc(read_slot_reg);
                                write_slot_next  = slot_inc(write_slot_reg);
                                newest_kind_next = req_entry.kind;
                            end
                        end
                        else
                        begin
                            wr_en            = 1'b1;
                            write_slot_next  = slot_inc(write_slot_reg);
                            occupancy_next   = occupancy_reg + CW'(1);
                            newest_kind_next = req_entry.kind;
                        end
                    end
                end
            end
            ST_POP_WAIT:
            begin
                // read data is back from the store
                rsp_ctl.load     = 1'b1;
                rsp_ctl.from_mem = 1'b1;
                rsp_ctl.status   = STATUS_OK;
                state_next       = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        rsp_ctl.fill = FILL_W'(occupancy_next);
    end

endmodule

// ===== rtl/coalescing_event_queue_core.sv =====
// ----------------------------------------------------------------------------
// coalescing_event_queue_core
// Ring-buffer event queue where consecutive move events merge into one entry.
// ----------------------------------------------------------------------------
//   channel  dir  handshake     payload
//   req      in   valid/ready   action, event_kind, first_value, second_value
//   rsp      out  valid/ready   status, popped_kind/first/second, fill_level
//   cfg      in   cfg_we        cfg_index, cfg_data
//
// A push is handled at the accepting edge: the entry write and the response
// load happen there. A pop reads the entry memory, whose read port returns
// data in the cycle after the address, and the response loads from it then.
// Reset empties the queue and clears both registers; no clearing pass.
// req is held off while a pop read is in flight or the response register
// is full and not being taken.
// ----------------------------------------------------------------------------
module coalescing_event_queue_core #(
    parameter int QUEUE_DEPTH = 32
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_we,
    input  logic [ceq_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [ceq_pkg::CFG_W-1:0]       cfg_data,
    ceq_req_if.sink                         req,
    ceq_rsp_if.source                       rsp
);
    import ceq_pkg::*;

    localparam int AW = $clog2(QUEUE_DEPTH);

    logic              enabled_reg;
    logic [KIND_W-1:0] move_code_reg;
    logic              rsp_valid_reg;
    logic [1:0]        status_reg;
    logic [FILL_W-1:0] fill_reg;
    logic              from_mem_reg;
    logic              out_free;
    entry_t            req_entry;
    entry_t            wr_data;
    entry_t            rd_data;
    logic              wr_en;
    logic              rd_en;
    logic [AW-1:0]     wr_addr;
    logic [AW-1:0]     rd_addr;
    rsp_ctl_t          rsp_ctl;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            enabled_reg   <= 1'b0;
            move_code_reg <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_QUEUE_ENABLED: enabled_reg   <= cfg_data[0];
                REG_MOVE_CODE:     move_code_reg <= cfg_data[KIND_W-1:0];
                default:           ;
            endcase
        end
    end

    assign req_entry.kind   = req.event_kind;
    assign req_entry.first  = req.first_value;
    assign req_entry.second = req.second_value;

    assign out_free = !rsp_valid_reg || rsp.ready;

    ceq_ctrl #(
        .QUEUE_DEPTH (QUEUE_DEPTH),
        .AW          (AW)
    ) u_ctrl (
        .clk           (clk),
        .rst_n         (rst_n),
        .queue_enabled (enabled_reg),
        .move_code     (move_code_reg),
        .req_valid     (req.valid),
        .req_action    (req.action),
        .req_entry     (req_entry),
        .out_free      (out_free),
        .req_ready     (req.ready),
        .wr_en         (wr_en),
        .wr_addr       (wr_addr),
        .wr_data       (wr_data),
        .rd_en         (rd_en),
        .rd_addr       (rd_addr),
        .rsp_ctl       (rsp_ctl)
    );

    ceq_store #(
        .QUEUE_DEPTH (QUEUE_DEPTH),
        .AW          (AW)
    ) u_store (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    // response register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_valid_reg <= 1'b0;
        end
        else if (rsp_ctl.load)
        begin
            rsp_valid_reg <= 1'b1;
        end
        else if (rsp.ready)
        begin
            rsp_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rsp_ctl.load)
        begin
            status_reg   <= rsp_ctl.status;
            fill_reg     <= rsp_ctl.fill;
            from_mem_reg <= rsp_ctl.from_mem;
        end
    end

    // popped fields come from the held read data, zero for other responses
    assign rsp.valid         = rsp_valid_reg;
    assign rsp.status        = status_reg;
    assign rsp.fill_level    = fill_reg;
    assign rsp.popped_kind   = from_mem_reg ? rd_data.kind   : '0;
    assign rsp.popped_first  = from_mem_reg ? rd_data.first  : '0;
    assign rsp.popped_second = from_mem_reg ? rd_data.second : '0;

    // a request is only taken when the response slot frees up
    assert property (@(posedge clk) disable iff (!rst_n)
        (req.valid && req.ready) |-> (!rsp_valid_reg || rsp.ready))
        else $error("request accepted while response slot busy");

    // a pop read and an entry write never share a cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        !(wr_en && rd_en))
        else $error("entry write and pop read in the same cycle");

    // non-ok responses carry no popped entry
    assert property (@(posedge clk) disable iff (!rst_n)
        (rsp.valid && (rsp.status == STATUS_EMPTY || rsp.status == STATUS_REJECTED))
        |-> (rsp.popped_kind == '0 && rsp.popped_first == '0
             && rsp.popped_second == '0))
        else $error("popped fields set on a failed request");

    // a loaded response is presented in the next cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_ctl.load |=> rsp.valid)
        else $error("loaded response not presented");

endmodule

// ===== dv/ceq_response_checker.sv =====
// ----------------------------------------------------------------------------
// ceq_response_checker
// Watches the request, response and register ports of the coalescing event
// queue, keeps its own copy of the ring buffer and compares every response.
// ----------------------------------------------------------------------------
module ceq_response_checker #(
    parameter int QUEUE_DEPTH = 32
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_we,
    input  logic [ceq_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [ceq_pkg::CFG_W-1:0]     cfg_data,
    ceq_req_if                            req,
    ceq_rsp_if                            rsp,
    output int                            fail_count,
    output int                            pending_count
);
    import ceq_pkg::*;

    // one response as the block should return it
    typedef struct packed {
        logic [1:0]               status;
        logic [KIND_W-1:0]        kind;
        logic signed [WORD_W-1:0] first;
        logic signed [WORD_W-1:0] second;
        logic [FILL_W-1:0]        fill;
    } queue_response_t;

    // shadow of the ring buffer and registers
    entry_t            slots [QUEUE_DEPTH];
    int                oldest_slot = 0;
    int                next_free_slot = 0;
    int                queued = 0;
    logic              pushes_enabled = 1'b0;
    logic [KIND_W-1:0] motion_code = '0;

    queue_response_t   awaited_responses [$];
    int                mismatches = 0;
    int                awaited_count = 0;

    assign fail_count    = mismatches;
    assign pending_count = awaited_count;

    task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
        $display("%0t mismatch %s: got %0h expected %0h", $realtime, what, got, want);
        mismatches++;
    endtask

    // apply one request to the shadow queue and return its response
    function automatic queue_response_t apply_request(logic action, logic [KIND_W-1:0] kind,
                                                      logic signed [WORD_W-1:0] first,
                                                      logic signed [WORD_W-1:0] second);
        queue_response_t r;
        int newest;
        r = '0;
        r.status = STATUS_OK;
        newest = (next_free_slot == 0) ? QUEUE_DEPTH - 1 : next_free_slot - 1;
        if (action == ACTION_POP)
        begin
            if (queued == 0)
            begin
                r.status = STATUS_EMPTY;
            end
            else
            begin
                r.kind   = slots[oldest_slot].kind;
                r.first  = slots[oldest_slot].first;
                r.second = slots[oldest_slot].second;
                oldest_slot = (oldest_slot + 1) % QUEUE_DEPTH;
                queued--;
            end
        end
        else if (!pushes_enabled)
        begin
            r.status = STATUS_REJECTED;
        end
        else if (kind == motion_code && queued > 0 && slots[newest].kind == motion_code)
        begin
            // motion merges into the newest entry
            slots[newest].first  = first;
            slots[newest].second = second;
        end
        else if (!(queued >= QUEUE_DEPTH && kind == motion_code))
        begin
            // full queue: other events push out the oldest, motion is dropped
            if (queued >= QUEUE_DEPTH)
            begin
                oldest_slot = (oldest_slot + 1) % QUEUE_DEPTH;
                queued--;
            end
            slots[next_free_slot].kind   = kind;
            slots[next_free_slot].first  = first;
            slots[next_free_slot].second = second;
            next_free_slot = (next_free_slot + 1) % QUEUE_DEPTH;
            queued++;
        end
        r.fill = FILL_W'(queued);
        return r;
    endfunction

    always @(posedge clk)
    begin
        queue_response_t want;
        if (rst_n)
        begin
            // register writes
            if (cfg_we)
            begin
                if (cfg_index == REG_QUEUE_ENABLED)
                    pushes_enabled = cfg_data[0];
                else if (cfg_index == REG_MOVE_CODE)
                    motion_code = cfg_data[KIND_W-1:0];
            end

            // compare an accepted response with the oldest expectation
            if (rsp.valid === 1'b1 && rsp.ready === 1'b1)
            begin
                if (awaited_responses.size() == 0)
                begin
                    report_mismatch("unexpected response status", 32'(rsp.status), '0);
                end
                else
                begin
                    want = awaited_responses.pop_front();
                    if (rsp.status !== want.status)
                        report_mismatch("status", 32'(rsp.status), 32'(want.status));
                    if (rsp.popped_kind !== want.kind)
                        report_mismatch("popped_kind", 32'(rsp.popped_kind), 32'(want.kind));
                    if (rsp.popped_first !== want.first)
                        report_mismatch("popped_first", rsp.popped_first, want.first);
                    if (rsp.popped_second !== want.second)
                        report_mismatch("popped_second", rsp.popped_second, want.second);
                    if (rsp.fill_level !== want.fill)
                        report_mismatch("fill_level", 32'(rsp.fill_level), 32'(want.fill));
                end
            end

            // predict the response of an accepted request
            if (req.valid === 1'b1 && req.ready === 1'b1)
                awaited_responses.push_back(apply_request(req.action, req.event_kind,
                                                          req.first_value, req.second_value));

            awaited_count = awaited_responses.size();
        end
    end

endmodule

// ===== dv/tb_coalescing_event_queue_core.sv =====
// ----------------------------------------------------------------------------
// tb_coalescing_event_queue_core
// Drives push and pop requests through the event queue under several register
// settings, with random gaps and stalls, and reports the checker's verdict.
// ----------------------------------------------------------------------------
module tb_coalescing_event_queue_core;
    import ceq_pkg::*;

    localparam int QUIET_LIMIT  = 2000;
    localparam int HOLD_CYCLES  = 80;
    localparam int DRAIN_CYCLES = 8;

    logic                 clk;
    logic                 rst_n;
    logic                 cfg_we;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CFG_W-1:0]     cfg_data;

    int fail_count;
    int pending_count;
    int quiet_cycles = 0;
    int stall_left = 0;
    bit idling_on = 1'b1;
    bit hold_pending = 1'b0;

    ceq_req_if req_ch ();
    ceq_rsp_if rsp_ch ();

    coalescing_event_queue_core dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .req       (req_ch),
        .rsp       (rsp_ch)
    );

    ceq_response_checker resp_check (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .req           (req_ch),
        .rsp           (rsp_ch),
        .fail_count    (fail_count),
        .pending_count (pending_count)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // response side: short random stalls, plus one long hold on request
    initial
    begin
        rsp_ch.ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (stall_left == 0)
            begin
                if (hold_pending)
                begin
                    stall_left = HOLD_CYCLES;
                    hold_pending = 1'b0;
                end
                else if (idling_on && $urandom_range(0, 4) == 0)
                begin
                    stall_left = $urandom_range(1, 3);
                end
            end
            if (stall_left > 0)
            begin
                rsp_ch.ready = 1'b0;
                stall_left--;
            end
            else
            begin
                rsp_ch.ready = 1'b1;
            end
        end
    end

    // no progress on either channel for too long ends the run
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= QUIET_LIMIT)
            begin
                $display("status: fail");
                $finish;
            end
        end
    end

    // data word with a bias toward the extremes
    function automatic logic signed [WORD_W-1:0] pick_word();
        case ($urandom_range(0, 9))
            0:       return 32'sh8000_0000;
            1:       return 32'sh7fff_ffff;
            2:       return '0;
            3:       return -32'sd1;
            default: return $urandom;
        endcase
    endfunction

    // offer one request and hold it until taken
    task automatic send_request(logic action, logic [KIND_W-1:0] kind,
                                logic signed [WORD_W-1:0] first,
                                logic signed [WORD_W-1:0] second);
        int gap;
        gap = (idling_on && $urandom_range(0, 4) == 0) ? $urandom_range(1, 3) : 0;
        @(negedge clk);
        if (gap > 0)
        begin
            req_ch.valid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        req_ch.valid        = 1'b1;
        req_ch.action       = action;
        req_ch.event_kind   = kind;
        req_ch.first_value  = first;
        req_ch.second_value = second;
        do @(posedge clk); while (req_ch.ready !== 1'b1);
    endtask

    // write both registers once the queue has gone quiet
    task automatic write_config(logic enable, logic [KIND_W-1:0] code);
        @(negedge clk);
        req_ch.valid = 1'b0;
        wait (pending_count == 0);
        repeat (DRAIN_CYCLES) @(posedge clk);
        @(negedge clk);
        cfg_we    = 1'b1;
        cfg_index = REG_QUEUE_ENABLED;
        cfg_data  = CFG_W'(enable);
        @(negedge clk);
        cfg_index = REG_MOVE_CODE;
        cfg_data  = code;
        @(negedge clk);
        cfg_we = 1'b0;
    endtask

    // random traffic with a given push share and motion share
    task automatic run_traffic(int count, int push_pct, int move_pct, logic [KIND_W-1:0] code);
        logic              action;
        logic [KIND_W-1:0] kind;
        for (int i = 0; i < count; i++)
        begin
            action = ($urandom_range(0, 99) < push_pct) ? ACTION_PUSH : ACTION_POP;
            kind   = ($urandom_range(0, 99) < move_pct) ? code : KIND_W'($urandom_range(0, 255));
            send_request(action, kind, pick_word(), pick_word());
        end
    endtask

    initial
    begin
        logic [KIND_W-1:0] code;

        rst_n               = 1'b0;
        cfg_we              = 1'b0;
        cfg_index           = REG_QUEUE_ENABLED;
        cfg_data            = '0;
        req_ch.valid        = 1'b0;
        req_ch.action       = ACTION_PUSH;
        req_ch.event_kind   = '0;
        req_ch.first_value  = '0;
        req_ch.second_value = '0;
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // out of reset: pushes rejected, pop finds nothing
        send_request(ACTION_PUSH, 8'h11, 32'sd5, 32'sd6);
        send_request(ACTION_POP, 8'h00, '0, '0);

        // enabled: extremes, motion merging, motion after another kind
        write_config(1'b1, 8'h40);
        send_request(ACTION_PUSH, 8'h00, 32'sh8000_0000, 32'sh7fff_ffff);
        send_request(ACTION_PUSH, 8'hff, '0, -32'sd1);
        send_request(ACTION_PUSH, 8'h40, 32'sd100, -32'sd100);
        send_request(ACTION_PUSH, 8'h40, 32'sh1234_5678, 32'sh5555_aaaa);
        send_request(ACTION_PUSH, 8'h40, -32'sd1, 32'sh8000_0000);
        send_request(ACTION_PUSH, 8'h41, 32'sh7fff_ffff, '0);
        send_request(ACTION_PUSH, 8'h40, 32'sd7, 32'sd8);
        send_request(ACTION_POP, 8'h00, '0, '0);
        send_request(ACTION_POP, 8'h00, '0, '0);

        // disabled: push rejected, pops still drain the queue
        write_config(1'b0, 8'h40);
        send_request(ACTION_PUSH, 8'h40, 32'sd1, 32'sd2);
        send_request(ACTION_POP, 8'h00, '0, '0);
        send_request(ACTION_POP, 8'h00, '0, '0);
        send_request(ACTION_POP, 8'h00, '0, '0);
        send_request(ACTION_POP, 8'h00, '0, '0);

        // motion code at both extremes
        write_config(1'b1, 8'h00);
        run_traffic(120, 75, 30, 8'h00);
        write_config(1'b1, 8'hff);
        hold_pending = 1'b1;
        run_traffic(100, 85, 40, 8'hff);

        // disabled with a loaded queue
        write_config(1'b0, 8'h5a);
        run_traffic(60, 50, 20, 8'h5a);

        // no idling on either side
        code = KIND_W'($urandom_range(1, 254));
        idling_on = 1'b0;
        write_config(1'b1, code);
        run_traffic(120, 45, 35, code);

        // push heavy: full queue, eviction and dropped motion
        code = KIND_W'($urandom_range(1, 254));
        idling_on = 1'b1;
        write_config(1'b1, code);
        run_traffic(120, 90, 20, code);

        // pop heavy: drain to empty
        write_config(1'b1, 8'h80);
        run_traffic(80, 20, 50, 8'h80);

        // last stretch without idling
        code = KIND_W'($urandom_range(1, 254));
        idling_on = 1'b0;
        write_config(1'b1, code);
        run_traffic(100, 60, 40, code);

        @(negedge clk);
        req_ch.valid = 1'b0;
        wait (pending_count == 0);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (fail_count == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule

// ===== coalescing_event_queue_core.f =====
rtl/ceq_pkg.sv
rtl/ceq_channels.sv
rtl/ceq_store.sv
rtl/ceq_ctrl.sv
rtl/coalescing_event_queue_core.sv
dv/ceq_response_checker.sv
dv/tb_coalescing_event_queue_core.sv
